>>> rtl/positional_ordered_list_assert.svh
// Assertion macros for the positional ordered list RTL.
// Included by the top level; define NO_ASSERTIONS to drop the checks.
`ifndef POSITIONAL_ORDERED_LIST_ASSERT_SVH
`define POSITIONAL_ORDERED_LIST_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Property that must hold at every clock edge out of reset.
`define POL_ASSERT(lbl, ck, rn, prop) \
	lbl: assert property (@(posedge ck) disable iff (!rn) prop) \
		else $error("positional_ordered_list: check failed");

// Condition that must never be seen out of reset.
`define POL_NEVER(lbl, ck, rn, expr) \
	`POL_ASSERT(lbl, ck, rn, !(expr))

`else

`define POL_ASSERT(lbl, ck, rn, prop)
`define POL_NEVER(lbl, ck, rn, expr)

`endif

`endif

>>> rtl/pol_pkg.sv
// Shared types and constants for the positional ordered list.
// No dependencies; imported by every module of the block.
`default_nettype none

package pol_pkg;

	localparam int KIND_W      = 2;
	localparam int POS_W       = 8;
	localparam int VAL_W       = 32;
	localparam int NUM_W       = 7;   // insert_index and count fields
	localparam int STATUS_W    = 2;
	localparam int S_TDATA_W   = 40;  // position, value
	localparam int M_TDATA_W   = 48;  // status, read_value, insert_index, count

	typedef enum logic [KIND_W-1:0] {
		KIND_INSERT = 2'd0,
		KIND_REMOVE = 2'd1,
		KIND_GET    = 2'd2,
		KIND_CLEAR  = 2'd3
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE    = 2'd0,
		ST_BAD_POS = 2'd1,
		ST_FULL    = 2'd2
	} status_t;

	// Broadcast to every cell of the chain.
	typedef struct packed {
		logic ins;  // shift up above the target, load the target
		logic rem;  // shift down from the target upward
		logic rd;   // target cell drives the read bus
	} cell_ctl_t;

endpackage

`default_nettype wire

>>> rtl/positional_ordered_list.sv
// Positional ordered list: a chain of CAPACITY cells shifting in parallel.
// Throughput: one request per cycle while m_tready does not stall the output,
// every kind (insert, remove, get, clear). Results pass the decode and read
// tree register, then the output register.
// Reset: arst_n clears the element count and the pipeline valids; cell
// contents are not reset and are only read below the count.
`default_nettype none

`include "positional_ordered_list_assert.svh"

module positional_ordered_list #(
	parameter int CAPACITY = 64
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [pol_pkg::S_TDATA_W-1:0] s_tdata,  // position[7:0], value[39:8]
	input  wire logic [pol_pkg::KIND_W-1:0]    s_tuser,  // kind[1:0]
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic      [pol_pkg::M_TDATA_W-1:0] m_tdata   // status[1:0], read_value[33:2],
	                                                     // insert_index[40:34], count[47:41]
);
	import pol_pkg::*;

	localparam int CW   = $clog2(CAPACITY + 1);
	localparam int AW   = $clog2(CAPACITY);
	localparam int CMPW = (CW > NUM_W) ? CW : NUM_W;

	// decode
	kind_t             kind;
	logic [POS_W-1:0]  pos;
	logic [VAL_W-1:0]  val;
	logic [CMPW-1:0]   pos_x;
	logic [CMPW-1:0]   n_x;
	logic              pos_ok;
	logic              full;
	logic [CMPW-1:0]   ins_at;
	logic [CMPW-1:0]   ins_idx;
	logic [CMPW-1:0]   idx;
	logic [CW-1:0]     cnt_nx;
	logic [CMPW-1:0]   cnt_ext;
	status_t           st;
	cell_ctl_t         ctl;
	logic [AW-1:0]     at;
	logic              acc;
	logic              adv;

	logic [CW-1:0]     cnt_q;

	// stage 1
	logic              v_s1;
	status_t           st_s1;
	logic [NUM_W-1:0]  idx_s1;
	logic [NUM_W-1:0]  cnt_s1;

	// output register
	logic                 m_tvalid_q;
	logic [M_TDATA_W-1:0] m_tdata_q;

	logic [CAPACITY-1:0][VAL_W-1:0] cell_q;
	logic [CAPACITY-1:0][VAL_W-1:0] rd_gate;
	logic [VAL_W-1:0]               rd_val;

	assign adv      = !m_tvalid_q || m_tready;
	assign s_tready = !v_s1 || adv;
	assign acc      = s_tvalid && s_tready;

	always_comb begin
		kind   = kind_t'(s_tuser);
		pos    = s_tdata[POS_W-1:0];
		val    = s_tdata[S_TDATA_W-1:POS_W];
		pos_x  = CMPW'(pos[POS_W-2:0]);
		n_x    = CMPW'(cnt_q);
		pos_ok = !pos[POS_W-1] && (pos_x < n_x);
		full   = (cnt_q == CW'(CAPACITY));

		// front for empty list or non-positive position, append past the end
		if (cnt_q == '0 || pos[POS_W-1] || pos_x == '0) begin
			ins_at = '0;
		end else if (pos_x >= n_x) begin
			ins_at = n_x;
		end else begin
			ins_at = pos_x;
		end

		if (ins_at == '0) begin
			ins_idx = '0;
		end else if (ins_at == n_x) begin
			ins_idx = CMPW'(n_x + CMPW'(1));
		end else begin
			ins_idx = ins_at;
		end

		st     = ST_DONE;
		idx    = '0;
		cnt_nx = cnt_q;
		ctl    = '0;
		at     = pos_x[AW-1:0];

		unique case (kind)
			KIND_INSERT: begin
				if (full) begin
					st = ST_FULL;
				end else begin
					ctl.ins = acc;
					at      = ins_at[AW-1:0];
					idx     = ins_idx;
					cnt_nx  = CW'(cnt_q + CW'(1));
				end
			end
			KIND_REMOVE: begin
				if (!pos_ok) begin
					st = ST_BAD_POS;
				end else begin
					ctl.rem = acc;
					cnt_nx  = CW'(cnt_q - CW'(1));
				end
			end
			KIND_GET: begin
				if (!pos_ok) begin
					st = ST_BAD_POS;
				end else begin
					ctl.rd = 1'b1;
				end
			end
			KIND_CLEAR: begin
				cnt_nx = '0;
			end
		endcase

		cnt_ext = CMPW'(cnt_nx);
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [VAL_W-1:0] left;
		logic [VAL_W-1:0] right;

		if (i == 0) begin : g_first
			assign left = '0;
		end else begin : g_mid_l
			assign left = cell_q[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right = cell_q[i];
		end else begin : g_mid_r
			assign right = cell_q[i+1];
		end

		pol_cell #(
			.IDX (i),
			.AW  (AW)
		) u_cell (
			.clk     (clk),
			.ctl     (ctl),
			.at      (at),
			.din     (val),
			.left    (left),
			.right   (right),
			.q       (cell_q[i]),
			.rd_data (rd_gate[i])
		);
	end

	pol_rd_tree #(
		.N (CAPACITY)
	) u_rd_tree (
		.clk  (clk),
		.ld   (acc),
		.din  (rd_gate),
		.dout (rd_val)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			v_s1       <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (acc) begin
				cnt_q <= cnt_nx;
			end
			if (s_tready) begin
				v_s1 <= acc;
			end
			if (adv) begin
				m_tvalid_q <= v_s1;
			end
		end
	end

	// payload: no reset
	always_ff @(posedge clk) begin
		if (acc) begin
			st_s1  <= st;
			idx_s1 <= idx[NUM_W-1:0];
			cnt_s1 <= cnt_ext[NUM_W-1:0];
		end
		if (adv && v_s1) begin
			m_tdata_q <= {cnt_s1, idx_s1, rd_val, st_s1};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	`POL_NEVER(a_cnt_bound, clk, arst_n, cnt_q > CW'(CAPACITY))
	`POL_ASSERT(a_full_holds, clk, arst_n, (acc && kind == KIND_INSERT && full) |=> $stable(cnt_q))
	`POL_ASSERT(a_clear_empties, clk, arst_n, (acc && kind == KIND_CLEAR) |=> (cnt_q == '0))
	`POL_ASSERT(a_full_no_idx, clk, arst_n, (v_s1 && st_s1 == ST_FULL) |-> (idx_s1 == '0))

endmodule

`default_nettype wire

>>> rtl/pol_cell.sv
// One storage cell of the list chain: holds one element, takes its left
// or right neighbor on insert/remove. Depends on pol_pkg.
`default_nettype none

module pol_cell #(
	parameter int IDX = 0,
	parameter int AW  = 6
) (
	input  wire logic                     clk,
	input  wire pol_pkg::cell_ctl_t       ctl,
	input  wire logic [AW-1:0]            at,
	input  wire logic [pol_pkg::VAL_W-1:0] din,
	input  wire logic [pol_pkg::VAL_W-1:0] left,
	input  wire logic [pol_pkg::VAL_W-1:0] right,
	output logic      [pol_pkg::VAL_W-1:0] q,
	output logic      [pol_pkg::VAL_W-1:0] rd_data
);
	import pol_pkg::*;

	localparam logic [AW-1:0] MY_IDX = AW'(IDX);

	logic hit;
	logic above;

	assign hit   = (MY_IDX == at);
	assign above = (MY_IDX > at);

	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (hit) begin
				q <= din;
			end else if (above) begin
				q <= left;
			end
		end else if (ctl.rem) begin
			if (hit || above) begin
				q <= right;
			end
		end
	end

	assign rd_data = (ctl.rd && hit) ? q : '0;

endmodule

`default_nettype wire

>>> rtl/pol_rd_tree.sv
// Read bus of the cell chain: OR of the gated cell outputs, first level
// in groups of eight registered, second level combinational. Uses pol_pkg.
`default_nettype none

module pol_rd_tree #(
	parameter int N = 64
) (
	input  wire logic                              clk,
	input  wire logic                              ld,
	input  wire logic [N-1:0][pol_pkg::VAL_W-1:0]  din,
	output logic      [pol_pkg::VAL_W-1:0]         dout
);
	import pol_pkg::*;

	localparam int GRP = 8;
	localparam int NG  = (N + GRP - 1) / GRP;

	logic [NG-1:0][VAL_W-1:0] grp_or;
	logic [NG-1:0][VAL_W-1:0] grp_s1;

	for (genvar g = 0; g < NG; g++) begin : g_grp
		always_comb begin
			grp_or[g] = '0;
			for (int k = 0; k < GRP; k++) begin
				if (g * GRP + k < N) begin
					grp_or[g] = grp_or[g] | din[g * GRP + k];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			grp_s1 <= grp_or;
		end
	end

	always_comb begin
		dout = '0;
		for (int g = 0; g < NG; g++) begin
			dout = dout | grp_s1[g];
		end
	end

endmodule

`default_nettype wire
